// ===== rtl/gbt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gbt_pkg - shared types and codes for the graph traversal block
// Field widths, request and status codes, and configuration register indexes.
// ============================================================================
package gbt_pkg;

   localparam int VERTEX_W = 6;
   localparam int VCOUNT_W = 7;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [STATUS_W-1:0] status_type;

   // request action codes
   localparam logic ACT_ADD_EDGE = 1'b0;
   localparam logic ACT_TRAVERSE = 1'b1;

   // traversal order codes
   localparam logic MODE_BFS = 1'b0;
   localparam logic MODE_DFS = 1'b1;

   // result status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVERSAL_MODE = 1'b1;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

// ===== rtl/gbt_adj_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gbt_adj_store - adjacency storage
// Neighbour list memory and per-vertex degree memory, registered reads.
// Degree entries carry valid bits so a vertex never written reads degree 0.
// ============================================================================
module gbt_adj_store import gbt_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [$clog2(MAX_VERTICES)-1:0]             deg_rd_addr,
   output logic [$clog2(MAX_DEGREE+1)-1:0]             deg_rd_data,
   input  logic                                        deg_we,
   input  logic [$clog2(MAX_VERTICES)-1:0]             deg_wr_addr,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]             deg_wr_data,
   input  logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0]  nbr_rd_addr,
   output vertex_type                                  nbr_rd_data,
   input  logic                                        nbr_we,
   input  logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0]  nbr_wr_addr,
   input  vertex_type                                  nbr_wr_data
);

   localparam int DW    = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;

   logic [DW-1:0]     deg_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] deg_valid_ff;
   logic [DW-1:0]     deg_data_ff;
   logic              deg_hit_ff;
   vertex_type        nbr_mem [DEPTH];
   vertex_type        nbr_data_ff;

   // valid bits: cleared by reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_valid_ff <= '0;
         deg_hit_ff   <= 1'b0;
      end else begin
         if (deg_we) begin
            deg_valid_ff[deg_wr_addr] <= 1'b1;
         end
         deg_hit_ff <= deg_valid_ff[deg_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wr_addr] <= deg_wr_data;
      end
      deg_data_ff <= deg_mem[deg_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_wr_addr] <= nbr_wr_data;
      end
      nbr_data_ff <= nbr_mem[nbr_rd_addr];
   end

   assign deg_rd_data = deg_hit_ff ? deg_data_ff : '0;
   assign nbr_rd_data = nbr_data_ff;

endmodule

// ===== rtl/graph_bfs_dfs_traversal_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// graph_bfs_dfs_traversal_top - undirected graph store with BFS/DFS walk
// Builds neighbour lists from add-edge requests and walks the whole graph
// in breadth-first or depth-first order on a traverse request.
// ============================================================================
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ---------------------------
//  request   req_action, req_edge_u, req_edge_v      start & !busy
//  result    rsp_visited_vertex, rsp_last, rsp_status rsp_valid, one cycle only
//  config    csr_index, csr_wdata                    csr_write_en, no wait
//
//  An add-edge request holds busy through S_E_RDV and S_E_CHK when rejected,
//  and through S_E_WRV as well when stored: two degree reads on the single
//  degree read port, then one neighbour write per endpoint on the single
//  neighbour write port. The status shows in the first cycle with busy low.
//  A walk makes one neighbour memory read per list entry under the sequencer,
//  and a depth-first walk also reloads the degree on each stack pop.
//  Reset is synchronous; it clears degrees (through valid bits), the
//  configuration, and the sequencer. No clearing pass is needed.
//  The receiver cannot stall; each result is shown for exactly one cycle.
//  The last vertex of a walk is held one step so it can carry the last flag.
//
module graph_bfs_dfs_traversal_top import gbt_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  vertex_type            req_edge_u,
   input  vertex_type            req_edge_v,
   output logic                  rsp_valid,
   output vertex_type            rsp_visited_vertex,
   output logic                  rsp_last,
   output status_type            rsp_status,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VCOUNT_W-1:0]   csr_wdata
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int DW     = $clog2(MAX_DEGREE + 1);
   localparam int NBR_AW = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int STK_W  = VERTEX_W + DW;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_E_RDV  = 4'd1;
   localparam logic [3:0] S_E_CHK  = 4'd2;
   localparam logic [3:0] S_E_WRV  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_B_POP  = 4'd5;
   localparam logic [3:0] S_B_LOAD = 4'd6;
   localparam logic [3:0] S_B_DEGW = 4'd7;
   localparam logic [3:0] S_B_NEXT = 4'd8;
   localparam logic [3:0] S_B_CHK  = 4'd9;
   localparam logic [3:0] S_D_DEG  = 4'd10;
   localparam logic [3:0] S_D_DEGW = 4'd11;
   localparam logic [3:0] S_D_NEXT = 4'd12;
   localparam logic [3:0] S_D_CHK  = 4'd13;
   localparam logic [3:0] S_D_POPW = 4'd14;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [VCOUNT_W-1:0]     vcount_ff, vcount_in;
   logic                    mode_ff, mode_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        sp_ff, sp_in;

   // payload state
   vertex_type              u_ff, u_in;
   vertex_type              v_ff, v_in;
   logic [DW-1:0]           du_ff, du_in;
   logic [DW-1:0]           dv_ff, dv_in;
   logic [VCOUNT_W-1:0]     s_ff, s_in;
   vertex_type              top_v_ff, top_v_in;
   logic [DW-1:0]           top_i_ff, top_i_in;
   logic [DW-1:0]           cur_deg_ff, cur_deg_in;
   vertex_type              pend_vertex_ff, pend_vertex_in;
   vertex_type              rsp_vertex_ff, rsp_vertex_in;
   logic                    rsp_last_ff, rsp_last_in;
   status_type              rsp_status_ff, rsp_status_in;

   // memory ports
   logic [VIDX_W-1:0]       deg_rd_addr;
   logic [DW-1:0]           deg_rd;
   logic                    deg_we;
   logic [VIDX_W-1:0]       deg_wr_addr;
   logic [DW-1:0]           deg_wr_data;
   logic [NBR_AW-1:0]       nbr_rd_addr;
   vertex_type              nbr_rd;
   logic                    nbr_we;
   logic [NBR_AW-1:0]       nbr_wr_addr;
   vertex_type              nbr_wr_data;

   vertex_type              q_mem [MAX_VERTICES];
   vertex_type              q_rd_ff;
   logic                    q_we;
   logic [VIDX_W-1:0]       q_wr_addr;
   vertex_type              q_wr_data;
   logic [VIDX_W-1:0]       q_rd_addr;

   logic [STK_W-1:0]        stk_mem [MAX_VERTICES];
   logic [STK_W-1:0]        stk_rd_ff;
   logic                    stk_we;
   logic [VIDX_W-1:0]       stk_wr_addr;
   logic [STK_W-1:0]        stk_wr_data;
   logic [VIDX_W-1:0]       stk_rd_addr;

   // datapath helpers
   logic [VCOUNT_W-1:0]     n_eff;
   logic                    emit_en;
   vertex_type              emit_vertex;
   logic                    flush;
   logic                    w_ok;
   logic                    u_oor;
   logic                    v_oor;
   logic                    list_full;
   logic [DW:0]             du_plus2;
   logic [CNT_W-1:0]        sp_less1;
   logic [CNT_W-1:0]        sp_less2;

   function automatic logic [NBR_AW-1:0] nbr_addr(input vertex_type vx,
                                                  input logic [DW-1:0] ix);
      logic [NBR_AW-1:0] base;
      base = NBR_AW'(vx[VIDX_W-1:0]) * NBR_AW'(MAX_DEGREE);
      return base + NBR_AW'(ix);
   endfunction

   gbt_adj_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_adj_store (
      .clock       (clock),
      .reset       (reset),
      .deg_rd_addr (deg_rd_addr),
      .deg_rd_data (deg_rd),
      .deg_we      (deg_we),
      .deg_wr_addr (deg_wr_addr),
      .deg_wr_data (deg_wr_data),
      .nbr_rd_addr (nbr_rd_addr),
      .nbr_rd_data (nbr_rd),
      .nbr_we      (nbr_we),
      .nbr_wr_addr (nbr_wr_addr),
      .nbr_wr_data (nbr_wr_data)
   );

   // clamp the vertex count to the storage size
   assign n_eff = (vcount_ff > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES) : vcount_ff;

   // a neighbour is taken when it is in range and not yet marked
   assign w_ok = ({1'b0, nbr_rd} < n_eff) && !visited_ff[nbr_rd[VIDX_W-1:0]];

   // edge checks: range first, then room in both lists
   assign u_oor    = {1'b0, u_ff} >= n_eff;
   assign v_oor    = {1'b0, v_ff} >= n_eff;
   assign du_plus2 = (DW+1)'(du_ff) + (DW+1)'(2);
   always_comb begin
      if (u_ff == v_ff) begin
         list_full = du_plus2 > (DW+1)'(MAX_DEGREE);
      end else begin
         list_full = ((DW+1)'(du_ff) >= (DW+1)'(MAX_DEGREE)) ||
                     ((DW+1)'(deg_rd) >= (DW+1)'(MAX_DEGREE));
      end
   end

   assign sp_less1 = sp_ff - CNT_W'(1);
   assign sp_less2 = sp_ff - CNT_W'(2);

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      vcount_in      = vcount_ff;
      mode_in        = mode_ff;
      visited_in     = visited_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      sp_in          = sp_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      du_in          = du_ff;
      dv_in          = dv_ff;
      s_in           = s_ff;
      top_v_in       = top_v_ff;
      top_i_in       = top_i_ff;
      cur_deg_in     = cur_deg_ff;

      deg_rd_addr    = top_v_ff[VIDX_W-1:0];
      deg_we         = 1'b0;
      deg_wr_addr    = u_ff[VIDX_W-1:0];
      deg_wr_data    = DW'(du_ff + DW'(1));
      nbr_rd_addr    = nbr_addr(top_v_ff, top_i_ff);
      nbr_we         = 1'b0;
      nbr_wr_addr    = nbr_addr(u_ff, du_ff);
      nbr_wr_data    = v_ff;
      q_we           = 1'b0;
      q_wr_addr      = tail_ff[VIDX_W-1:0];
      q_wr_data      = nbr_rd;
      q_rd_addr      = head_ff[VIDX_W-1:0];
      stk_we         = 1'b0;
      stk_wr_addr    = sp_less1[VIDX_W-1:0];
      stk_wr_data    = {top_v_ff, top_i_ff};
      stk_rd_addr    = sp_less2[VIDX_W-1:0];

      emit_en        = 1'b0;
      emit_vertex    = nbr_rd;
      flush          = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_vertex_in  = '0;
      rsp_last_in    = 1'b0;
      rsp_status_in  = STATUS_OK;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:   vcount_in = csr_wdata;
            CSR_TRAVERSAL_MODE: mode_in   = csr_wdata[0];
            default:            vcount_in = vcount_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            deg_rd_addr = req_edge_u[VIDX_W-1:0];
            if (start) begin
               if (req_action == ACT_ADD_EDGE) begin
                  u_in     = req_edge_u;
                  v_in     = req_edge_v;
                  state_in = S_E_RDV;
               end else begin
                  visited_in = '0;
                  s_in       = '0;
                  head_in    = '0;
                  tail_in    = '0;
                  sp_in      = '0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_E_RDV: begin
            // degree of u arrives, issue read of v
            deg_rd_addr = v_ff[VIDX_W-1:0];
            du_in       = deg_rd;
            state_in    = S_E_CHK;
         end
         S_E_CHK: begin
            dv_in = (u_ff == v_ff) ? DW'(du_ff + DW'(1)) : deg_rd;
            if (u_oor || v_oor || list_full) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = (u_oor || v_oor) ? STATUS_RANGE : STATUS_FULL;
               state_in      = S_IDLE;
            end else begin
               nbr_we   = 1'b1;
               deg_we   = 1'b1;
               state_in = S_E_WRV;
            end
         end
         S_E_WRV: begin
            nbr_we        = 1'b1;
            nbr_wr_addr   = nbr_addr(v_ff, dv_ff);
            nbr_wr_data   = u_ff;
            deg_we        = 1'b1;
            deg_wr_addr   = v_ff[VIDX_W-1:0];
            deg_wr_data   = DW'(dv_ff + DW'(1));
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = STATUS_OK;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            if (s_ff >= n_eff) begin
               flush    = 1'b1;
               state_in = S_IDLE;
            end else if (visited_ff[s_ff[VIDX_W-1:0]]) begin
               s_in = s_ff + VCOUNT_W'(1);
            end else begin
               visited_in[s_ff[VIDX_W-1:0]] = 1'b1;
               if (mode_ff == MODE_BFS) begin
                  q_we      = 1'b1;
                  q_wr_data = s_ff[VERTEX_W-1:0];
                  tail_in   = tail_ff + CNT_W'(1);
                  state_in  = S_B_POP;
               end else begin
                  emit_en     = 1'b1;
                  emit_vertex = s_ff[VERTEX_W-1:0];
                  top_v_in    = s_ff[VERTEX_W-1:0];
                  top_i_in    = '0;
                  sp_in       = CNT_W'(1);
                  state_in    = S_D_DEG;
               end
            end
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               state_in = S_SCAN;
            end else begin
               head_in  = head_ff + CNT_W'(1);
               state_in = S_B_LOAD;
            end
         end
         S_B_LOAD: begin
            emit_en     = 1'b1;
            emit_vertex = q_rd_ff;
            top_v_in    = q_rd_ff;
            top_i_in    = '0;
            deg_rd_addr = q_rd_ff[VIDX_W-1:0];
            state_in    = S_B_DEGW;
         end
         S_B_DEGW: begin
            cur_deg_in = deg_rd;
            state_in   = S_B_NEXT;
         end
         S_B_NEXT: begin
            if (top_i_ff < cur_deg_ff) begin
               top_i_in = top_i_ff + DW'(1);
               state_in = S_B_CHK;
            end else begin
               state_in = S_B_POP;
            end
         end
         S_B_CHK: begin
            if (w_ok) begin
               visited_in[nbr_rd[VIDX_W-1:0]] = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + CNT_W'(1);
            end
            state_in = S_B_NEXT;
         end
         S_D_DEG: begin
            state_in = S_D_DEGW;
         end
         S_D_DEGW: begin
            cur_deg_in = deg_rd;
            state_in   = S_D_NEXT;
         end
         S_D_NEXT: begin
            if (top_i_ff < cur_deg_ff) begin
               top_i_in = top_i_ff + DW'(1);
               state_in = S_D_CHK;
            end else if (sp_ff == CNT_W'(1)) begin
               sp_in    = '0;
               state_in = S_SCAN;
            end else begin
               sp_in    = sp_less1;
               state_in = S_D_POPW;
            end
         end
         S_D_CHK: begin
            if (w_ok) begin
               visited_in[nbr_rd[VIDX_W-1:0]] = 1'b1;
               emit_en  = 1'b1;
               stk_we   = 1'b1;
               top_v_in = nbr_rd;
               top_i_in = '0;
               sp_in    = sp_ff + CNT_W'(1);
               state_in = S_D_DEG;
            end else begin
               state_in = S_D_NEXT;
            end
         end
         S_D_POPW: begin
            top_v_in = stk_rd_ff[STK_W-1:DW];
            top_i_in = stk_rd_ff[DW-1:0];
            state_in = S_D_DEG;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold one vertex back so the final one can carry the last flag
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_vertex_in = pend_vertex_ff;
      if (emit_en) begin
         pend_valid_in  = 1'b1;
         pend_vertex_in = emit_vertex;
      end else if (flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vcount_ff     <= VCOUNT_RESET;
         mode_ff       <= MODE_BFS;
         visited_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         sp_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         mode_ff       <= mode_in;
         visited_ff    <= visited_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in || ((emit_en || flush) && pend_valid_ff);
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         sp_ff         <= sp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u_ff           <= u_in;
      v_ff           <= v_in;
      du_ff          <= du_in;
      dv_ff          <= dv_in;
      s_ff           <= s_in;
      top_v_ff       <= top_v_in;
      top_i_ff       <= top_i_in;
      cur_deg_ff     <= cur_deg_in;
      pend_vertex_ff <= pend_vertex_in;
      if ((emit_en || flush) && pend_valid_ff) begin
         // release the held vertex; it is last only on the final drain
         rsp_vertex_ff <= pend_vertex_ff;
         rsp_last_ff   <= flush;
         rsp_status_ff <= STATUS_OK;
      end else begin
         rsp_vertex_ff <= rsp_vertex_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // BFS work queue
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wr_addr] <= q_wr_data;
      end
      q_rd_ff <= q_mem[q_rd_addr];
   end

   // DFS descent stack, entries below the top
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wr_addr] <= stk_wr_data;
      end
      stk_rd_ff <= stk_mem[stk_rd_addr];
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

   // a rejected edge is always a single, final result
   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_last)
      else $error("rejected edge result without last flag");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_RANGE))
      else $error("undefined status code");

   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= CNT_W'(MAX_VERTICES)))
      else $error("work queue pointers out of order");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_W'(MAX_VERTICES))
      else $error("descent stack overflow");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held vertex left behind at idle");

endmodule

// ===== bench/tb_graph_bfs_dfs_traversal_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_graph_bfs_dfs_traversal_top - self-checking bench for the graph walker
// Drives add-edge and traverse requests with random gaps, predicts every
// status and every visited vertex from a behavioral copy of the graph, and
// checks each result strobe field by field against the oldest prediction.
// ============================================================================
module tb_graph_bfs_dfs_traversal_top;
   import gbt_pkg::*;

   localparam int MAX_VERT       = 64;
   localparam int MAX_DEG        = 8;
   localparam int REQUEST_TARGET = 470;   // total requests, directed part included
   localparam int QUIET_SPAN     = 60;    // final requests sent without gaps
   localparam int SETTLE_CYCLES  = 16;    // pause after the last result before a CSR write

   typedef struct packed {
      vertex_type vertex;
      logic       last;
      status_type status;
   } visit_rec_type;

   // DUT connections; every input starts at a known value
   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 busy;
   logic                 req_action   = ACT_ADD_EDGE;
   vertex_type           req_edge_u   = '0;
   vertex_type           req_edge_v   = '0;
   logic                 rsp_valid;
   vertex_type           rsp_visited_vertex;
   logic                 rsp_last;
   status_type           rsp_status;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_VERTEX_COUNT;
   logic [VCOUNT_W-1:0]  csr_wdata    = '0;

   // behavioral copy of the graph and its configuration
   vertex_type           adj_list [MAX_VERT][MAX_DEG];
   int unsigned          degree [MAX_VERT];
   logic [VCOUNT_W-1:0]  vcount_reg;
   logic                 mode_reg;

   visit_rec_type        expected_visits [$];
   visit_rec_type        head_visit;
   int                   error_count   = 0;
   int                   requests_sent = 0;
   bit                   quiet_tail    = 1'b0;

   graph_bfs_dfs_traversal_top #(
      .MAX_VERTICES (MAX_VERT),
      .MAX_DEGREE   (MAX_DEG)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_edge_u         (req_edge_u),
      .req_edge_v         (req_edge_v),
      .rsp_valid          (rsp_valid),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Graph predictor
   // ------------------------------------------------------------------------

   // Counts above the vertex capacity act as the full capacity.
   function automatic int unsigned live_count();
      return (vcount_reg > VCOUNT_W'(MAX_VERT)) ? MAX_VERT : int'(vcount_reg);
   endfunction

   // Range is checked before room; a rejected edge leaves both lists alone.
   function automatic void add_edge_model(vertex_type u, vertex_type v);
      int unsigned   n;
      visit_rec_type rec;
      n = live_count();
      rec.vertex = '0;
      rec.last   = 1'b1;
      rec.status = STATUS_OK;
      if (u >= n || v >= n)
         rec.status = STATUS_RANGE;
      else if (u == v) begin
         // a self-loop lands twice in its own list, so it needs two free slots
         if (degree[u] + 2 > MAX_DEG)
            rec.status = STATUS_FULL;
      end else if (degree[u] >= MAX_DEG || degree[v] >= MAX_DEG)
         rec.status = STATUS_FULL;
      if (rec.status == STATUS_OK) begin
         adj_list[u][degree[u]] = v;
         degree[u]++;
         adj_list[v][degree[v]] = u;
         degree[v]++;
      end
      expected_visits = {expected_visits, rec};
   endfunction

   // Walk every component from the lowest unvisited vertex upward. Stored
   // neighbours at or above the live count are stale and get skipped.
   function automatic void walk_graph();
      int unsigned n;
      logic [MAX_VERT-1:0] seen;
      vertex_type  order [MAX_VERT];
      vertex_type  fifo [MAX_VERT];
      vertex_type  stack_v [MAX_VERT];
      int unsigned stack_i [MAX_VERT];
      int unsigned head, tail, sp, i, emitted;
      vertex_type  c, w;
      visit_rec_type rec;
      n       = live_count();
      seen    = '0;
      emitted = 0;
      for (int s = 0; s < n; s++) begin
         if (!seen[s]) begin
            seen[s] = 1'b1;
            if (mode_reg == MODE_BFS) begin
               // mark on enqueue
               head = 0;
               tail = 1;
               fifo[0] = vertex_type'(s);
               while (head < tail) begin
                  c = fifo[head];
                  head++;
                  order[emitted] = c;
                  emitted++;
                  for (i = 0; i < degree[c]; i++) begin
                     w = adj_list[c][i];
                     if (w < n && !seen[w] && tail < MAX_VERT) begin
                        seen[w] = 1'b1;
                        fifo[tail] = w;
                        tail++;
                     end
                  end
               end
            end else begin
               // mark on entry; each frame keeps its next neighbour position
               order[emitted] = vertex_type'(s);
               emitted++;
               stack_v[0] = vertex_type'(s);
               stack_i[0] = 0;
               sp = 1;
               while (sp > 0) begin
                  c = stack_v[sp-1];
                  i = stack_i[sp-1];
                  if (i < degree[c]) begin
                     w = adj_list[c][i];
                     stack_i[sp-1] = i + 1;
                     if (w < n && !seen[w] && sp < MAX_VERT) begin
                        seen[w] = 1'b1;
                        order[emitted] = w;
                        emitted++;
                        stack_v[sp] = w;
                        stack_i[sp] = 0;
                        sp++;
                     end
                  end else
                     sp--;
               end
            end
         end
      end
      for (i = 0; i < emitted; i++) begin
         rec.vertex = order[i];
         rec.last   = (i == emitted - 1);
         rec.status = STATUS_OK;
         expected_visits = {expected_visits, rec};
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checker: every strobe must match the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_visits.size() == 0) begin
            error_count++;
            $error("unexpected result: visited_vertex %0d last %0b status %0d",
                   rsp_visited_vertex, rsp_last, rsp_status);
         end else begin
            head_visit = expected_visits.pop_front();
            if (rsp_visited_vertex !== head_visit.vertex) begin
               error_count++;
               $error("visited_vertex: expected %0d, actual %0d",
                      head_visit.vertex, rsp_visited_vertex);
            end
            if (rsp_last !== head_visit.last) begin
               error_count++;
               $error("last: expected %0b, actual %0b", head_visit.last, rsp_last);
            end
            if (rsp_status !== head_visit.status) begin
               error_count++;
               $error("status: expected %0d, actual %0d", head_visit.status, rsp_status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Present one request, hold it until start meets a low busy, then predict.
   // Leave start high when no gap follows so back-to-back requests stream.
   task automatic send_request(input logic act, input vertex_type u, input vertex_type v);
      req_action <= act;
      req_edge_u <= u;
      req_edge_v <= v;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      if (act == ACT_ADD_EDGE)
         add_edge_model(u, v);
      else
         walk_graph();
      requests_sent++;
      if (!quiet_tail && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Hold off new requests until every predicted result has arrived, then
   // give a walk that emits nothing time to finish.
   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write one register while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [VCOUNT_W-1:0] data);
      wait_for_results();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_VERTEX_COUNT)
         vcount_reg = data;
      else
         mode_reg = data[0];
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset leaves 64 isolated vertices in breadth-first mode: expect 0..63.
   task automatic test_empty_graph();
      send_request(ACT_TRAVERSE, 6'd63, 6'd63);
   endtask

   // Extreme endpoints, a duplicate edge and self-loops, then a walk.
   task automatic test_edge_extremes();
      send_request(ACT_ADD_EDGE, 6'd0, 6'd63);
      send_request(ACT_ADD_EDGE, 6'd63, 6'd0);
      send_request(ACT_ADD_EDGE, 6'd5, 6'd5);
      send_request(ACT_ADD_EDGE, 6'd63, 6'd63);
      send_request(ACT_TRAVERSE, 6'd0, 6'd0);
   endtask

   // Fill vertex 1: a self-loop with one slot left is refused, a plain edge
   // still fits, then the same edge in the other order is refused on the full list.
   task automatic test_degree_limit();
      for (int k = 2; k <= 8; k++)
         send_request(ACT_ADD_EDGE, 6'd1, vertex_type'(k));
      send_request(ACT_ADD_EDGE, 6'd1, 6'd1);
      send_request(ACT_ADD_EDGE, 6'd1, 6'd9);
      send_request(ACT_ADD_EDGE, 6'd9, 6'd1);
      write_csr(CSR_TRAVERSAL_MODE, {6'd0, MODE_DFS});
      send_request(ACT_TRAVERSE, 6'd21, 6'd42);
   endtask

   // Zero vertices, an oversized count, one vertex, and stale neighbours
   // after the count drops below stored endpoints.
   task automatic test_vertex_count_limits();
      write_csr(CSR_VERTEX_COUNT, 7'd0);
      send_request(ACT_ADD_EDGE, 6'd0, 6'd0);
      send_request(ACT_TRAVERSE, 6'd0, 6'd0);     // no results at all
      write_csr(CSR_VERTEX_COUNT, 7'd127);
      send_request(ACT_ADD_EDGE, 6'd62, 6'd63);
      send_request(ACT_TRAVERSE, 6'd0, 6'd0);
      write_csr(CSR_VERTEX_COUNT, 7'd1);
      send_request(ACT_ADD_EDGE, 6'd0, 6'd1);
      send_request(ACT_ADD_EDGE, 6'd1, 6'd0);
      send_request(ACT_TRAVERSE, 6'd0, 6'd0);
      write_csr(CSR_VERTEX_COUNT, 7'd10);
      write_csr(CSR_TRAVERSAL_MODE, {6'd0, MODE_BFS});
      send_request(ACT_TRAVERSE, 6'd0, 6'd0);
   endtask

   // Phases of random configuration, a burst of edges mostly inside the live
   // range, then a walk. A few stray walks and out-of-range edges add noise.
   task automatic test_random_traffic();
      int unsigned      n, pick;
      vertex_type       u, v;
      logic [VCOUNT_W-1:0] count_val;
      while (requests_sent < REQUEST_TARGET) begin
         pick = $urandom_range(19);
         if (pick < 8)
            count_val = VCOUNT_W'($urandom_range(2, 16));
         else if (pick < 14)
            count_val = VCOUNT_W'($urandom_range(17, 63));
         else if (pick < 17)
            count_val = VCOUNT_W'(MAX_VERT);
         else if (pick < 18)
            count_val = VCOUNT_W'($urandom_range(65, 127));
         else
            count_val = VCOUNT_W'($urandom_range(1));
         write_csr(CSR_VERTEX_COUNT, count_val);
         // upper data bits are junk for the mode register
         write_csr(CSR_TRAVERSAL_MODE, VCOUNT_W'($urandom_range(127)));
         n = live_count();
         repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(9);
            if (n == 0 || pick == 0) begin
               u = vertex_type'($urandom_range(63));
               v = vertex_type'($urandom_range(63));
            end else if (pick == 1) begin
               u = vertex_type'($urandom_range(n - 1));
               v = u;
            end else begin
               u = vertex_type'($urandom_range(n - 1));
               v = vertex_type'($urandom_range(n - 1));
            end
            if ($urandom_range(15) == 0)
               send_request(ACT_TRAVERSE, vertex_type'($urandom), vertex_type'($urandom));
            else
               send_request(ACT_ADD_EDGE, u, v);
         end
         send_request(ACT_TRAVERSE, vertex_type'($urandom), vertex_type'($urandom));
         // run the tail of the stimulus with no gaps
         if (requests_sent >= REQUEST_TARGET - QUIET_SPAN)
            quiet_tail = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      vcount_reg = VCOUNT_RESET;
      mode_reg   = MODE_BFS;
      for (int k = 0; k < MAX_VERT; k++)
         degree[k] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_graph();
      test_edge_extremes();
      test_degree_limit();
      test_vertex_count_limits();
      test_random_traffic();

      // drain everything still in flight before judging the run
      wait_for_results();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond a run where every request were a full-size walk.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
